/* rtl/core/fsp_pkg.sv */
// Format-spec parser package: phase codes, character codes, field codes,
// the parse-state struct and small byte classifiers.
// No dependencies.
package fsp_pkg;

  localparam int FILL_W  = 21;
  localparam int FIELD_W = 24;

  // grammar phases
  localparam logic [3:0] PH_LEAD       = 4'd0;
  localparam logic [3:0] PH_ALIGN      = 4'd1;
  localparam logic [3:0] PH_SIGN       = 4'd2;
  localparam logic [3:0] PH_Z          = 4'd3;
  localparam logic [3:0] PH_HASH       = 4'd4;
  localparam logic [3:0] PH_ZERO       = 4'd5;
  localparam logic [3:0] PH_WIDTH      = 4'd6;
  localparam logic [3:0] PH_WIDTH_IN   = 4'd7;
  localparam logic [3:0] PH_GROUP      = 4'd8;
  localparam logic [3:0] PH_DOT        = 4'd9;
  localparam logic [3:0] PH_PREC_FIRST = 4'd10;
  localparam logic [3:0] PH_PREC_IN    = 4'd11;
  localparam logic [3:0] PH_TYPE       = 4'd12;
  localparam logic [3:0] PH_DONE       = 4'd13;
  localparam logic [3:0] PH_ERR        = 4'd14;

  // spec characters
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // field codes
  localparam logic [2:0] AL_NONE   = 3'd0;
  localparam logic [2:0] AL_LEFT   = 3'd1;
  localparam logic [2:0] AL_RIGHT  = 3'd2;
  localparam logic [2:0] AL_CENTER = 3'd3;
  localparam logic [2:0] AL_PAD    = 3'd4;

  localparam logic [1:0] SG_NONE  = 2'd0;
  localparam logic [1:0] SG_PLUS  = 2'd1;
  localparam logic [1:0] SG_MINUS = 2'd2;
  localparam logic [1:0] SG_SPACE = 2'd3;

  localparam logic [1:0] GS_NONE  = 2'd0;
  localparam logic [1:0] GS_COMMA = 2'd1;
  localparam logic [1:0] GS_UNDER = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIGITS  = 2'd1;
  localparam logic [1:0] ST_NOPREC  = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  // flag bit positions
  localparam int FL_ALT     = 0;
  localparam int FL_ZERO    = 1;
  localparam int FL_IMPLIED = 2;

  typedef struct packed {
    logic [3:0]         phase;
    logic [FILL_W-1:0]  fill;
    logic [2:0]         align;
    logic [1:0]         sign;
    logic [2:0]         flags;
    logic [FIELD_W-1:0] width;
    logic [FIELD_W-1:0] prec;
    logic [1:0]         sep;
    logic [7:0]         type_code;
    logic [1:0]         err;
    logic               fill_given;
  } fsp_state_t;

  localparam fsp_state_t RESET_ST = '{
    phase: PH_LEAD, fill: 21'd32, align: AL_NONE, sign: SG_NONE, flags: 3'd0,
    width: '1, prec: '1, sep: GS_NONE, type_code: 8'd0, err: ST_OK,
    fill_given: 1'b0
  };

  // one UTF-8 step on the leading character
  typedef struct packed {
    logic              hold;      // keep collecting bytes
    logic              align_ok;  // the new byte sits right after the character
    logic [FILL_W-1:0] fill;      // decoded codepoint, 0 if malformed
    logic [FILL_W-1:0] cp_next;   // partial codepoint with the new byte
  } fsp_utf_t;

  function automatic logic [2:0] align_code(input logic [7:0] c);
    case (c)
      CH_LT:    align_code = AL_LEFT;
      CH_GT:    align_code = AL_RIGHT;
      CH_CARET: align_code = AL_CENTER;
      CH_EQ:    align_code = AL_PAD;
      default:  align_code = AL_NONE;
    endcase
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    if (b < 8'h80) lead_len = 3'd1;
    else if (b >= 8'hC2 && b <= 8'hDF) lead_len = 3'd2;
    else if (b >= 8'hE0 && b <= 8'hEF) lead_len = 3'd3;
    else if (b >= 8'hF0 && b <= 8'hF4) lead_len = 3'd4;
    else lead_len = 3'd1;
  endfunction

  function automatic logic [FILL_W-1:0] lead_bits(input logic [7:0] b);
    if (b >= 8'hC2 && b <= 8'hDF) lead_bits = FILL_W'(b[4:0]);
    else if (b >= 8'hE0 && b <= 8'hEF) lead_bits = FILL_W'(b[3:0]);
    else if (b >= 8'hF0 && b <= 8'hF4) lead_bits = FILL_W'(b[2:0]);
    else lead_bits = '0;
  endfunction

endpackage

/* rtl/core/fsp_utf8.sv */
// UTF-8 step for the leading character of a spec: checks one more byte
// against the held lead byte. Depends on fsp_pkg.
module fsp_utf8 import fsp_pkg::*; (
  input  logic [7:0]        lead,
  input  logic [2:0]        held,
  input  logic [7:0]        c,
  input  logic [FILL_W-1:0] cp,
  output fsp_utf_t          step
);

  logic [2:0] len;
  logic       cont_ok;

  assign len = lead_len(lead);

  always_comb begin
    cont_ok = (c[7:6] == 2'b10);
    if (held == 3'd1) begin
      if (lead == 8'hE0 && c < 8'hA0) cont_ok = 1'b0;
      if (lead == 8'hED && c > 8'h9F) cont_ok = 1'b0;
      if (lead == 8'hF0 && c < 8'h90) cont_ok = 1'b0;
      if (lead == 8'hF4 && c > 8'h8F) cont_ok = 1'b0;
    end
  end

  always_comb begin
    step.hold     = 1'b0;
    step.align_ok = 1'b1;
    step.fill     = cp;
    step.cp_next  = {cp[FILL_W-7:0], c[5:0]};
    if (len == 3'd1) begin
      // single byte or bad lead: bad lead decodes as 0
      step.fill = lead[7] ? '0 : FILL_W'(lead);
    end else if (held < len) begin
      if (!cont_ok) begin
        step.fill     = '0;
        step.align_ok = (held == 3'd1);
      end else begin
        step.hold = 1'b1;
      end
    end
  end

endmodule

/* rtl/core/fsp_feed.sv */
// Grammar step: applies one spec byte to the parse state, including the
// width/precision digit accumulation. Depends on fsp_pkg.
module fsp_feed import fsp_pkg::*; #(
  parameter int NUMBER_LIMIT = 8388607,
  localparam int ACC_W = $clog2(longint'(NUMBER_LIMIT) + 64'd1),
  localparam int SUM_W = ACC_W + 4
) (
  input  fsp_state_t       st,
  input  logic [ACC_W-1:0] accum,
  input  logic [7:0]       c,
  output fsp_state_t       st_next,
  output logic [ACC_W-1:0] accum_next
);

  logic [ACC_W-1:0] base;
  logic [SUM_W-1:0] sum;
  logic             over;
  logic             dig;
  logic [2:0]       acode;
  logic [3:0]       ph;
  logic             go;

  // only a running number continues from the accumulator
  assign base = (st.phase == PH_WIDTH_IN || st.phase == PH_PREC_IN) ? accum : '0;
  assign sum  = SUM_W'(base) * SUM_W'(4'd10) + SUM_W'(c[3:0]);
  assign over = sum > SUM_W'(NUMBER_LIMIT);
  assign dig  = is_digit(c);
  assign acode = align_code(c);

  always_comb begin
    st_next    = st;
    accum_next = accum;
    ph         = st.phase;
    go         = 1'b1;

    if (ph == PH_ERR) begin
      go = 1'b0;
    end else if (ph == PH_DONE) begin
      st_next.err = ST_INVALID;
      ph = PH_ERR;
      go = 1'b0;
    end

    if (go && ph == PH_ALIGN) begin
      ph = PH_SIGN;
      if (acode != AL_NONE) begin
        st_next.align = acode;
        go = 1'b0;
      end
    end
    if (go && ph == PH_SIGN) begin
      ph = PH_Z;
      if (c == CH_PLUS) begin
        st_next.sign = SG_PLUS;
        go = 1'b0;
      end else if (c == CH_MINUS) begin
        st_next.sign = SG_MINUS;
        go = 1'b0;
      end else if (c == CH_SPACE) begin
        st_next.sign = SG_SPACE;
        go = 1'b0;
      end
    end
    if (go && ph == PH_Z) begin
      ph = PH_HASH;
      if (c == CH_Z) go = 1'b0;
    end
    if (go && ph == PH_HASH) begin
      ph = PH_ZERO;
      if (c == CH_HASH) begin
        st_next.flags[FL_ALT] = 1'b1;
        go = 1'b0;
      end
    end
    if (go && ph == PH_ZERO) begin
      ph = PH_WIDTH;
      if (c == CH_ZERO) begin
        st_next.flags[FL_ZERO] = 1'b1;
        if (!st.fill_given) st_next.fill = FILL_W'(CH_ZERO);
        if (st.align == AL_NONE) begin
          st_next.fill  = FILL_W'(CH_ZERO);
          st_next.align = AL_PAD;
          st_next.flags[FL_IMPLIED] = 1'b1;
        end
        go = 1'b0;
      end
    end
    if (go && ph == PH_WIDTH) begin
      if (dig) begin
        if (over) begin
          st_next.err = ST_DIGITS;
          ph = PH_ERR;
        end else begin
          accum_next = ACC_W'(sum);
          ph = PH_WIDTH_IN;
        end
        go = 1'b0;
      end else begin
        ph = PH_GROUP;
      end
    end
    if (go && ph == PH_WIDTH_IN) begin
      if (dig) begin
        if (over) begin
          st_next.err = ST_DIGITS;
          ph = PH_ERR;
        end else begin
          accum_next = ACC_W'(sum);
        end
        go = 1'b0;
      end else begin
        st_next.width = FIELD_W'(accum);
        ph = PH_GROUP;
      end
    end
    if (go && ph == PH_GROUP) begin
      ph = PH_DOT;
      if (c == CH_COMMA) begin
        st_next.sep = GS_COMMA;
        go = 1'b0;
      end else if (c == CH_UNDER) begin
        st_next.sep = GS_UNDER;
        go = 1'b0;
      end
    end
    if (go && ph == PH_DOT) begin
      if (c == CH_DOT) begin
        ph = PH_PREC_FIRST;
        go = 1'b0;
      end else begin
        ph = PH_TYPE;
      end
    end
    if (go && ph == PH_PREC_FIRST) begin
      if (dig && !over) begin
        accum_next = ACC_W'(sum);
        ph = PH_PREC_IN;
      end else begin
        st_next.err = dig ? ST_DIGITS : ST_NOPREC;
        ph = PH_ERR;
      end
      go = 1'b0;
    end
    if (go && ph == PH_PREC_IN) begin
      if (dig) begin
        if (over) begin
          st_next.err = ST_DIGITS;
          ph = PH_ERR;
        end else begin
          accum_next = ACC_W'(sum);
        end
        go = 1'b0;
      end else begin
        st_next.prec = FIELD_W'(accum);
        ph = PH_TYPE;
      end
    end
    if (go && ph == PH_TYPE) begin
      st_next.type_code = c;
      ph = PH_DONE;
    end

    st_next.phase = ph;
  end

endmodule

/* rtl/core/format_spec_parser.sv */
// Format-spec parser top level: stream handshake, leading-character hold,
// finish and result packing. Depends on fsp_pkg, fsp_utf8, fsp_feed.
//
//  channel  | dir | beat content
//  ---------+-----+------------------------------------------------------
//  s_axis   | in  | tdata: spec_byte; tlast: last_byte; tuser: empty_spec
//  m_axis   | out | tdata: parsed fields and status (one beat per spec)
//
// One byte is taken every cycle while s_axis_tready is high. A result is
// registered in m_axis_tdata, or in the skid entry while m_axis stalls;
// the grammar step (one digit multiply-add and compare) sets the clock path.
// Synchronous reset puts the parser at the start of a spec with no held bytes.
// A two-entry output (result register plus skid) keeps s_axis_tready high
// while one result waits; it drops only when both entries are full.
module format_spec_parser import fsp_pkg::*; #(
  parameter int NUMBER_LIMIT = 8388607
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] spec_byte
  input  logic        s_axis_tlast,   // last_byte
  input  logic        s_axis_tuser,   // empty_spec
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [20:0] fill_char, [23:21] align_mode, [25:24] sign_mode,
  // [26] alternate_form, [27] zero_flag, [28] zero_implied,
  // [52:29] field_width, [54:53] group_sep, [78:55] precision_digits,
  // [86:79] type_code, [88:87] status, [95:89] zero
  output logic [95:0] m_axis_tdata
);

  localparam int ACC_W     = $clog2(longint'(NUMBER_LIMIT) + 64'd1);
  localparam int WIDTH_LSB = 29;
  localparam int STAT_LSB  = 87;

  // parse state
  fsp_state_t        st;
  logic [ACC_W-1:0]  accum;
  logic [2:0]        held_count;
  logic [7:0]        lead;
  logic [FILL_W-1:0] cpv;

  // output queue
  logic [95:0] skid_data;
  logic        skid_valid;

  logic s_accept;
  logic first;
  logic done;

  fsp_state_t        feed_in;
  fsp_state_t        fed;
  logic [ACC_W-1:0]  fed_acc;
  fsp_utf_t          us;

  fsp_state_t        tk_st;
  logic [ACC_W-1:0]  tk_acc;
  logic [2:0]        tk_held;
  logic [7:0]        tk_lead;
  logic [FILL_W-1:0] tk_cpv;

  fsp_state_t        fin;
  fsp_state_t        em;
  logic [95:0]       res_data;

  assign s_axis_tready = !skid_valid;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign done          = s_axis_tlast || s_axis_tuser;

  // First byte of a spec: run it through the grammar right away, as if no
  // fill were given, and hold it. If an align byte follows the character,
  // that guess is thrown away and the fill/align override takes over.
  assign first = (held_count == 3'd0) && (st.phase == PH_LEAD);

  always_comb begin
    feed_in = st;
    if (first) feed_in.phase = PH_ALIGN;
  end

  fsp_feed #(.NUMBER_LIMIT(NUMBER_LIMIT)) u_feed (
    .st         (feed_in),
    .accum      (accum),
    .c          (s_axis_tdata),
    .st_next    (fed),
    .accum_next (fed_acc)
  );

  fsp_utf8 u_utf8 (
    .lead (lead),
    .held (held_count),
    .c    (s_axis_tdata),
    .cp   (cpv),
    .step (us)
  );

  // take one byte
  always_comb begin
    tk_st   = fed;
    tk_acc  = fed_acc;
    tk_held = 3'd0;
    tk_lead = lead;
    tk_cpv  = cpv;
    if (first) begin
      tk_held = 3'd1;
      tk_lead = s_axis_tdata;
      tk_cpv  = lead_bits(s_axis_tdata);
    end else if (held_count != 3'd0) begin
      if (us.hold) begin
        // still inside a multi-byte character
        tk_st   = st;
        tk_acc  = accum;
        tk_held = held_count + 3'd1;
        tk_cpv  = us.cp_next;
      end else if (us.align_ok && align_code(s_axis_tdata) != AL_NONE) begin
        // character then align byte: it was a fill
        tk_st            = RESET_ST;
        tk_st.phase      = PH_SIGN;
        tk_st.fill       = us.fill;
        tk_st.fill_given = 1'b1;
        tk_st.align      = align_code(s_axis_tdata);
        tk_acc           = accum;
      end
      // otherwise the speculative grammar state just takes the byte
    end
  end

  // end of spec: close an open number, flag a dangling '.', and a
  // multi-byte character that never settled is invalid
  always_comb begin
    fin = tk_st;
    if (tk_held >= 3'd2) begin
      fin.err = ST_INVALID;
    end else begin
      case (tk_st.phase)
        PH_WIDTH_IN:   fin.width = FIELD_W'(tk_acc);
        PH_PREC_IN:    fin.prec  = FIELD_W'(tk_acc);
        PH_PREC_FIRST: fin.err   = ST_NOPREC;
        default:       fin.err   = tk_st.err;
      endcase
    end
  end

  // any error shows defaults; an empty spec shows defaults with status ok
  always_comb begin
    if (s_axis_tuser) begin
      em = RESET_ST;
    end else if (fin.err != ST_OK) begin
      em     = RESET_ST;
      em.err = fin.err;
    end else begin
      em = fin;
    end
  end

  assign res_data = {7'd0, em.err, em.type_code, em.prec, em.sep, em.width,
                     em.flags[FL_IMPLIED], em.flags[FL_ZERO], em.flags[FL_ALT],
                     em.sign, em.align, em.fill};

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= RESET_ST;
      accum      <= '0;
      held_count <= 3'd0;
      lead       <= 8'd0;
      cpv        <= '0;
    end else if (s_accept) begin
      if (done) begin
        st         <= RESET_ST;
        accum      <= '0;
        held_count <= 3'd0;
      end else begin
        st         <= tk_st;
        accum      <= tk_acc;
        held_count <= tk_held;
        lead       <= tk_lead;
        cpv        <= tk_cpv;
      end
    end
  end

  // result register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (!m_axis_tvalid || m_axis_tready) begin
        if (skid_valid) begin
          m_axis_tvalid <= 1'b1;
          skid_valid    <= 1'b0;
        end else begin
          m_axis_tvalid <= s_accept && done;
        end
      end else if (s_accept && done) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) m_axis_tdata <= skid_data;
      else            m_axis_tdata <= res_data;
    end else if (s_accept && done) begin
      skid_data <= res_data;
    end
  end

`ifndef NO_ASSERTIONS
  // skid entry only fills behind a waiting result
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid entry valid without output beat");

  // a UTF-8 character holds at most four bytes
  a_held_max: assert property (@(posedge clk) disable iff (rst)
    held_count <= 3'd4)
    else $error("held byte count above four");

  // every result returns the parser to the start of a spec
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (s_accept && done) |=> (st.phase == PH_LEAD && held_count == 3'd0))
    else $error("parser not restarted after result");

  // holding a leading character never coexists with an error
  a_hold_clean: assert property (@(posedge clk) disable iff (rst)
    held_count != 3'd0 |-> st.err == ST_OK)
    else $error("error recorded while leading character held");

  // error results carry default width
  a_err_default: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[STAT_LSB +: 2] != ST_OK)
      |-> m_axis_tdata[WIDTH_LSB +: FIELD_W] == '1)
    else $error("error result with non-default width");
`endif

endmodule
